// ----- hw/rtl/neon_glow_shader_assert.svh -----
// Assertion macros used by the neon glow shader top level.
`ifndef NEON_GLOW_SHADER_ASSERT_SVH
`define NEON_GLOW_SHADER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NGS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ngs_pkg.sv -----
// Package for the neon glow shader: widths, register codes, types and lookup tables.
package ngs_pkg;

    // Table depths.
    localparam int EXP_TABLE_DEPTH  = 1024;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int EXP_IDX_W        = $clog2(EXP_TABLE_DEPTH);
    localparam int SIN_IDX_W        = $clog2(SINE_TABLE_DEPTH);

    // Fixed-point constants.
    localparam longint unsigned ONE_Q30          = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30      = 64'd1686629713;
    localparam longint unsigned SEVEN_TENTHS_Q30 = 64'd751619277;
    localparam longint unsigned THREE_TENTHS_Q30 = 64'd322122547;
    localparam int              SIGMA_BASE       = 196608;
    localparam int              SIGMA_SCALE      = 10;

    // Datapath widths.
    localparam int DATA_W      = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int SIGMA_W     = 20;
    localparam int SIGMA_SQ_W  = 2 * SIGMA_W;
    localparam int DEN_W       = SIGMA_SQ_W + 1;
    localparam int MAG_SQ_W    = 31;
    localparam int NUM_SCALE   = 4096 * EXP_TABLE_DEPTH;
    localparam int NUM_W       = MAG_SQ_W + $clog2(NUM_SCALE) + 1;
    localparam int DIV_STAGES  = EXP_IDX_W + 1;
    localparam int CORE_W      = 31;
    localparam int INTEN_PROD_W = CORE_W + DATA_W;
    localparam int INTEN_W     = 21;
    localparam int PULSE_W     = 31;
    localparam int TINT_W      = 2 * DATA_W;
    localparam int SHADE_W     = TINT_W + PULSE_W;
    localparam int FRAC_W      = 24;
    localparam int PHASE_W     = FRAC_W + SIN_IDX_W + 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROUGHNESS   = 3'd0,
        CFG_EMISSIVE    = 3'd1,
        CFG_THRESHOLD   = 3'd2,
        CFG_COLOR_RED   = 3'd3,
        CFG_COLOR_GREEN = 3'd4,
        CFG_COLOR_BLUE  = 3'd5,
        CFG_PULSE_SPEED = 3'd6,
        CFG_ANIM_TIME   = 3'd7
    } t_cfg_idx;

    // Settings and derived terms handed from the register bank to the datapath.
    typedef struct packed {
        logic [SIGMA_SQ_W-1:0] sigma_sq;
        logic [DATA_W-1:0]     emissive_gain;
        logic [DATA_W-1:0]     bloom_level;
        logic [DATA_W-1:0]     color_red;
        logic [DATA_W-1:0]     color_green;
        logic [DATA_W-1:0]     color_blue;
        logic [PULSE_W-1:0]    pulse;
    } t_cfg;

    typedef logic [CORE_W-1:0]  t_exp_rom   [EXP_TABLE_DEPTH];
    typedef logic [PULSE_W-1:0] t_pulse_rom [SINE_TABLE_DEPTH];

    // Truncating unsigned long division by shift and subtract, used while the
    // tables are built.
    function automatic longint unsigned div_u64(longint unsigned a, longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], a[i]};
            if (r >= b) begin
                r    = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Gaussian falloff table: exp(-16k/depth) in Q1.30, from a truncated series
    // on a thirty-second of the argument followed by five rounded squarings.
    function automatic t_exp_rom gen_exp_rom();
        t_exp_rom          rom;
        longint unsigned   y;
        longint unsigned   t;
        longint unsigned   s;
        longint            sum;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            // The divisor is 32 times the depth, a power of two.
            y   = ((longint'(k) << 30) * 64'd16) >> (EXP_IDX_W + 5);
            t   = ONE_Q30;
            sum = longint'(ONE_Q30);
            for (int n = 1; n <= 12; n++) begin
                t = div_u64((t * y) >> 30, longint'(n));
                if ((n & 1) == 1) begin
                    sum = sum - longint'(t);
                end else begin
                    sum = sum + longint'(t);
                end
            end
            if (sum < 0) sum = 0;
            if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
            s = longint'(sum);
            for (int i = 0; i < 5; i++) begin
                s = (s * s + 64'd536870912) >> 30;
            end
            rom[k] = s[CORE_W-1:0];
        end
        return rom;
    endfunction

    // Pulse table: 0.7 + 0.3 sin(2 pi j / depth) in Q30, the sine built by
    // quadrant folding and a truncated odd series.
    function automatic t_pulse_rom gen_pulse_rom();
        t_pulse_rom        rom;
        longint unsigned   q;
        longint unsigned   xn;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   t;
        longint unsigned   s;
        longint unsigned   term;
        longint unsigned   p;
        longint            sum;
        logic              neg;
        for (int j = 0; j < SINE_TABLE_DEPTH; j++) begin
            q  = (64'd4 * longint'(j)) >> SIN_IDX_W;
            xn = 64'd4 * longint'(j) - (q << SIN_IDX_W);
            if (q[0]) xn = SINE_TABLE_DEPTH - xn;
            neg = (q >= 2);
            x   = (HALF_PI_Q30 * xn) >> SIN_IDX_W;
            x2  = (x * x) >> 30;
            t   = x;
            sum = longint'(x);
            for (int n = 1; n <= 12; n++) begin
                t = div_u64((t * x2) >> 30, longint'((2 * n) * (2 * n + 1)));
                if ((n & 1) == 1) begin
                    sum = sum - longint'(t);
                end else begin
                    sum = sum + longint'(t);
                end
            end
            if (sum < 0) sum = 0;
            if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
            s    = longint'(sum);
            term = (THREE_TENTHS_Q30 * s + 64'd536870912) >> 30;
            p    = neg ? (SEVEN_TENTHS_Q30 - term) : (SEVEN_TENTHS_Q30 + term);
            rom[j] = p[PULSE_W-1:0];
        end
        return rom;
    endfunction

    localparam t_exp_rom   EXP_ROM   = gen_exp_rom();
    localparam t_pulse_rom PULSE_ROM = gen_pulse_rom();

endpackage

// ----- hw/rtl/ngs_cfg.sv -----
// Configuration register bank with the derived sigma-squared and pulse terms.
module ngs_cfg
    import ngs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [DATA_W-1:0]     r_roughness;
    logic [DATA_W-1:0]     r_emissive_gain;
    logic [DATA_W-1:0]     r_bloom_level;
    logic [DATA_W-1:0]     r_color_red;
    logic [DATA_W-1:0]     r_color_green;
    logic [DATA_W-1:0]     r_color_blue;
    logic [DATA_W-1:0]     r_pulse_speed;
    logic [CFG_DATA_W-1:0] r_anim_time;

    logic [SIGMA_SQ_W-1:0] r_sigma_sq;
    logic [FRAC_W-1:0]     r_phase_frac;
    logic [SIN_IDX_W-1:0]  r_sin_idx;
    logic [PULSE_W-1:0]    r_pulse;

    logic [SIGMA_W-1:0]    n_sigma;
    logic [SIGMA_SQ_W-1:0] n_sigma_sq;
    logic [47:0]           n_phase_prod;
    logic [PHASE_W-1:0]    n_phase_scaled;
    logic [SIN_IDX_W:0]    n_sin_round;
    logic [SIN_IDX_W-1:0]  n_sin_idx;

    // Register writes; each write lands in the addressed register only.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roughness       <= '0;
            r_emissive_gain   <= DATA_W'(4096);
            r_bloom_level     <= '0;
            r_color_red       <= DATA_W'(4096);
            r_color_green     <= DATA_W'(4096);
            r_color_blue      <= DATA_W'(4096);
            r_pulse_speed     <= '0;
            r_anim_time       <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROUGHNESS:   r_roughness       <= i_cfg_data[DATA_W-1:0];
                CFG_EMISSIVE:    r_emissive_gain   <= i_cfg_data[DATA_W-1:0];
                CFG_THRESHOLD:   r_bloom_level     <= i_cfg_data[DATA_W-1:0];
                CFG_COLOR_RED:   r_color_red       <= i_cfg_data[DATA_W-1:0];
                CFG_COLOR_GREEN: r_color_green     <= i_cfg_data[DATA_W-1:0];
                CFG_COLOR_BLUE:  r_color_blue      <= i_cfg_data[DATA_W-1:0];
                CFG_PULSE_SPEED: r_pulse_speed     <= i_cfg_data[DATA_W-1:0];
                CFG_ANIM_TIME:   r_anim_time       <= i_cfg_data;
            endcase
        end
    end

    // Sigma in Q16 and its square, and the phase of the pulse as a table index.
    always_comb begin
        n_sigma        = SIGMA_W'(SIGMA_BASE) + SIGMA_W'(r_roughness) * SIGMA_W'(SIGMA_SCALE);
        n_sigma_sq     = SIGMA_SQ_W'(n_sigma) * SIGMA_SQ_W'(n_sigma);
        n_phase_prod   = 48'(r_anim_time) * 48'(r_pulse_speed);
        n_phase_scaled = (PHASE_W'(r_phase_frac) * PHASE_W'(SINE_TABLE_DEPTH)
                         + (PHASE_W'(1) << (FRAC_W - 1))) >> FRAC_W;
        n_sin_round    = n_phase_scaled[SIN_IDX_W:0];
        if (n_sin_round >= (SIN_IDX_W + 1)'(SINE_TABLE_DEPTH)) begin
            n_sin_round = n_sin_round - (SIN_IDX_W + 1)'(SINE_TABLE_DEPTH);
        end
        n_sin_idx      = n_sin_round[SIN_IDX_W-1:0];
    end

    // Derived terms follow the registers continuously, each one registered.
    always_ff @(posedge i_clk) begin
        r_sigma_sq   <= n_sigma_sq;
        r_phase_frac <= n_phase_prod[FRAC_W-1:0];
        r_sin_idx    <= n_sin_idx;
        r_pulse      <= (r_pulse_speed == '0) ? PULSE_W'(ONE_Q30) : PULSE_ROM[r_sin_idx];
    end

    assign o_cfg.sigma_sq        = r_sigma_sq;
    assign o_cfg.emissive_gain   = r_emissive_gain;
    assign o_cfg.bloom_level     = r_bloom_level;
    assign o_cfg.color_red       = r_color_red;
    assign o_cfg.color_green     = r_color_green;
    assign o_cfg.color_blue      = r_color_blue;
    assign o_cfg.pulse           = r_pulse;

endmodule

// ----- hw/rtl/ngs_div.sv -----
// Pipelined restoring divider giving the rounded exponent-table index, one quotient bit a stage.
module ngs_div
    import ngs_pkg::*;
(
    input  logic                  i_clk,
    input  logic [DIV_STAGES-1:0] i_en,
    input  logic [NUM_W-1:0]      i_num,
    input  logic [DEN_W-1:0]      i_den,
    output logic [EXP_IDX_W-1:0]  o_quo,
    output logic                  o_ovf
);

    logic [NUM_W-1:0]     r_rem [DIV_STAGES];
    logic [EXP_IDX_W-1:0] r_quo [DIV_STAGES];
    logic                 r_ovf [DIV_STAGES];

    logic [NUM_W-1:0]     n_rem [DIV_STAGES];
    logic [EXP_IDX_W-1:0] n_quo [DIV_STAGES];
    logic                 n_ovf [DIV_STAGES];
    logic [NUM_W-1:0]     n_shift_den [DIV_STAGES];

    // The first stage only flags a quotient beyond the table; each later stage
    // settles one bit, most significant first.
    always_comb begin
        n_shift_den[0] = NUM_W'(i_den) << EXP_IDX_W;
        n_rem[0]       = i_num;
        n_quo[0]       = '0;
        n_ovf[0]       = (i_num >= n_shift_den[0]);
        for (int s = 1; s < DIV_STAGES; s++) begin
            n_shift_den[s] = NUM_W'(i_den) << (EXP_IDX_W - s);
            n_ovf[s]       = r_ovf[s-1];
            if (r_rem[s-1] >= n_shift_den[s]) begin
                n_rem[s] = r_rem[s-1] - n_shift_den[s];
                n_quo[s] = {r_quo[s-1][EXP_IDX_W-2:0], 1'b1};
            end else begin
                n_rem[s] = r_rem[s-1];
                n_quo[s] = {r_quo[s-1][EXP_IDX_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
                r_ovf[s] <= n_ovf[s];
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];
    assign o_ovf = r_ovf[DIV_STAGES-1];

endmodule

// ----- hw/rtl/neon_glow_shader.sv -----
// Top level of the neon glow shader: per-pixel gaussian glow with a pulsed colour tint.
// Path: magnitude, square, numerator, the one-bit-a-stage divider for the table index, then the
// table lookup, intensity, glow, tint and output registers.
// Throughput: one item per cycle; each stage moves whenever the stage after it is free.
// Reset: synchronous, active low; empties the pipeline and restores register defaults.
module neon_glow_shader
    import ngs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [DATA_W-1:0] i_edge_dist,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [DATA_W-1:0]        o_glow,
    output logic [DATA_W-1:0]        o_out_red,
    output logic [DATA_W-1:0]        o_out_green,
    output logic [DATA_W-1:0]        o_out_blue
);

    `include "neon_glow_shader_assert.svh"

    // Stage positions along the pipeline.
    localparam int S_MAG      = 0;
    localparam int S_MAG_SQ   = 1;
    localparam int S_NUM      = 2;
    localparam int S_DIV      = 3;
    localparam int S_CORE     = S_DIV + DIV_STAGES;
    localparam int S_INTEN    = S_CORE + 1;
    localparam int S_GLOW     = S_CORE + 2;
    localparam int S_TINT     = S_CORE + 3;
    localparam int S_OUT      = S_CORE + 4;
    localparam int NUM_STAGES = S_OUT + 1;

    t_cfg                    cfg;
    logic [NUM_STAGES-1:0]   r_vld;
    logic [NUM_STAGES-1:0]   n_vld;
    logic [NUM_STAGES:0]     en;

    logic [DATA_W-1:0]       r_mag;
    logic [MAG_SQ_W-1:0]     r_mag_sq;
    logic [NUM_W-1:0]        r_num;
    logic [CORE_W-1:0]       r_core;
    logic [INTEN_W-1:0]      r_inten;
    logic [DATA_W-1:0]       r_glow;
    logic [DATA_W-1:0]       r_tint_glow;
    logic [TINT_W-1:0]       r_tint_red;
    logic [TINT_W-1:0]       r_tint_green;
    logic [TINT_W-1:0]       r_tint_blue;
    logic [DATA_W-1:0]       r_out_glow;
    logic [DATA_W-1:0]       r_out_red;
    logic [DATA_W-1:0]       r_out_green;
    logic [DATA_W-1:0]       r_out_blue;

    logic [DATA_W-1:0]       n_mag;
    logic [TINT_W-1:0]       n_mag_prod;
    logic [EXP_IDX_W-1:0]    div_quo;
    logic                    div_ovf;
    logic                    n_core_zero;
    logic [INTEN_PROD_W-1:0] n_inten_prod;
    logic [DATA_W-1:0]       n_glow;
    logic [SHADE_W-1:0]      n_shade_red;
    logic [SHADE_W-1:0]      n_shade_green;
    logic [SHADE_W-1:0]      n_shade_blue;

    ngs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // A stage takes new contents when it is empty or the stage after it moves on.
    always_comb begin
        en[NUM_STAGES] = i_out_ready;
        for (int s = NUM_STAGES - 1; s >= 0; s--) begin
            en[s] = en[s+1] | ~r_vld[s];
        end
        n_vld = {r_vld[NUM_STAGES-2:0], i_in_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NUM_STAGES; s++) begin
                if (en[s]) r_vld[s] <= n_vld[s];
            end
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[S_OUT];

    // Distance magnitude, its square and the rounded-division numerator.
    always_comb begin
        n_mag      = i_edge_dist[DATA_W-1] ? DATA_W'(-i_edge_dist) : DATA_W'(i_edge_dist);
        n_mag_prod = TINT_W'(r_mag) * TINT_W'(r_mag);
    end

    always_ff @(posedge i_clk) begin
        if (en[S_MAG])    r_mag    <= n_mag;
        if (en[S_MAG_SQ]) r_mag_sq <= n_mag_prod[MAG_SQ_W-1:0];
        if (en[S_NUM]) begin
            r_num <= NUM_W'(r_mag_sq) * NUM_W'(NUM_SCALE) + NUM_W'(cfg.sigma_sq);
        end
    end

    ngs_div u_div (
        .i_clk (i_clk),
        .i_en  (en[S_DIV +: DIV_STAGES]),
        .i_num (r_num),
        .i_den ({cfg.sigma_sq, 1'b0}),
        .o_quo (div_quo),
        .o_ovf (div_ovf)
    );

    // Table lookup, emissive gain, then threshold and saturation.
    always_comb begin
        n_core_zero  = div_ovf
                       || ({1'b0, div_quo} >= (EXP_IDX_W + 1)'(EXP_TABLE_DEPTH));
        n_inten_prod = (INTEN_PROD_W'(r_core) * INTEN_PROD_W'(cfg.emissive_gain)
                       + (INTEN_PROD_W'(1) << 25)) >> 26;
        if (r_inten <= INTEN_W'(cfg.bloom_level)) begin
            n_glow = '0;
        end else if (r_inten > INTEN_W'({DATA_W{1'b1}})) begin
            n_glow = '1;
        end else begin
            n_glow = r_inten[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_CORE])  r_core  <= n_core_zero ? '0 : EXP_ROM[div_quo];
        if (en[S_INTEN]) r_inten <= n_inten_prod[INTEN_W-1:0];
        if (en[S_GLOW])  r_glow  <= n_glow;
    end

    // Colour times glow, then times the pulse with rounding.
    always_comb begin
        n_shade_red   = (SHADE_W'(r_tint_red) * SHADE_W'(cfg.pulse)
                        + (SHADE_W'(1) << 45)) >> 46;
        n_shade_green = (SHADE_W'(r_tint_green) * SHADE_W'(cfg.pulse)
                        + (SHADE_W'(1) << 45)) >> 46;
        n_shade_blue  = (SHADE_W'(r_tint_blue) * SHADE_W'(cfg.pulse)
                        + (SHADE_W'(1) << 45)) >> 46;
    end

    always_ff @(posedge i_clk) begin
        if (en[S_TINT]) begin
            r_tint_glow  <= r_glow;
            r_tint_red   <= TINT_W'(cfg.color_red) * TINT_W'(r_glow);
            r_tint_green <= TINT_W'(cfg.color_green) * TINT_W'(r_glow);
            r_tint_blue  <= TINT_W'(cfg.color_blue) * TINT_W'(r_glow);
        end
        if (en[S_OUT]) begin
            r_out_glow  <= r_tint_glow;
            r_out_red   <= n_shade_red[DATA_W-1:0];
            r_out_green <= n_shade_green[DATA_W-1:0];
            r_out_blue  <= n_shade_blue[DATA_W-1:0];
        end
    end

    assign o_glow      = r_out_glow;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;

    // Input back-pressure only arises when every stage, the output too, is full.
    `NGS_ASSERT_IMPL(a_stall_only_when_full, i_clk, i_rst_n, !o_in_ready,
        o_out_valid && (&r_vld), "input stalled with an empty stage")

    // An input transfer always lands in the first stage.
    `NGS_ASSERT_NEXT(a_transfer_enters, i_clk, i_rst_n, i_in_valid && o_in_ready,
        r_vld[S_MAG], "input transfer lost at the first stage")

    // A dark pixel gives dark colour channels.
    `NGS_ASSERT_IMPL(a_zero_glow_dark, i_clk, i_rst_n, o_out_valid && (o_glow == '0),
        (o_out_red == '0) && (o_out_green == '0) && (o_out_blue == '0),
        "colour present with zero glow")

    // Any glow that survives lies above the bloom threshold or is saturated.
    `NGS_ASSERT_IMPL(a_glow_above_threshold, i_clk, i_rst_n,
        o_out_valid && (o_glow != '0),
        (o_glow > cfg.bloom_level) || (o_glow == '1),
        "glow not above the bloom threshold")

endmodule

// ----- test/ngs_checker.sv -----
// Scoreboard for the neon glow shader: mirrors the registers, predicts each pixel and compares.
`timescale 1ns / 1ps

module ngs_checker
    import ngs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic signed [DATA_W-1:0] i_edge_dist,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [DATA_W-1:0]        i_glow,
    input  logic [DATA_W-1:0]        i_out_red,
    input  logic [DATA_W-1:0]        i_out_green,
    input  logic [DATA_W-1:0]        i_out_blue,
    output int                       o_errors,
    output int                       o_pending
);

    typedef struct packed {
        logic [DATA_W-1:0] glow;
        logic [DATA_W-1:0] red;
        logic [DATA_W-1:0] green;
        logic [DATA_W-1:0] blue;
    } t_pixel;

    t_pixel pixels_due[$];

    // Local copy of the register bank.
    logic [15:0] roughness_r;
    logic [15:0] gain_r;
    logic [15:0] threshold_r;
    logic [15:0] red_r;
    logic [15:0] green_r;
    logic [15:0] blue_r;
    logic [15:0] speed_r;
    logic [31:0] time_r;

    // Gaussian falloff: truncated series on a thirty-second of the argument, squared five times.
    function automatic longint unsigned gauss_core(longint unsigned k);
        longint unsigned y;
        longint unsigned t;
        longint unsigned s;
        longint          acc;
        y   = ((k << 30) * 16) / (32 * EXP_TABLE_DEPTH);
        t   = ONE_Q30;
        acc = longint'(ONE_Q30);
        for (int n = 1; n <= 12; n++) begin
            t = ((t * y) >> 30) / longint'(n);
            acc = (n % 2 == 1) ? acc - longint'(t) : acc + longint'(t);
        end
        if (acc < 0) acc = 0;
        if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
        s = longint'(acc);
        repeat (5) s = (s * s + 64'd536870912) >> 30;
        return s;
    endfunction

    // Pulse factor for a phase index: 0.7 plus or minus 0.3 times the sine magnitude.
    function automatic longint unsigned pulse_at(longint unsigned j);
        longint unsigned quad;
        longint unsigned xn;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned term;
        longint          acc;
        quad = (4 * j) / SINE_TABLE_DEPTH;
        xn   = 4 * j - quad * SINE_TABLE_DEPTH;
        if (quad[0]) xn = SINE_TABLE_DEPTH - xn;
        x   = (HALF_PI_Q30 * xn) / SINE_TABLE_DEPTH;
        x2  = (x * x) >> 30;
        t   = x;
        acc = longint'(x);
        for (int n = 1; n <= 12; n++) begin
            t = ((t * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            acc = (n % 2 == 1) ? acc - longint'(t) : acc + longint'(t);
        end
        if (acc < 0) acc = 0;
        if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
        term = (THREE_TENTHS_Q30 * longint'(acc) + 64'd536870912) >> 30;
        return (quad >= 2) ? SEVEN_TENTHS_Q30 - term : SEVEN_TENTHS_Q30 + term;
    endfunction

    function automatic logic [DATA_W-1:0] tint(logic [15:0] colour, longint unsigned glow,
                                               longint unsigned pulse);
        longint unsigned p;
        p = longint'(colour) * glow * pulse;
        return DATA_W'((p + (64'd1 << 45)) >> 46);
    endfunction

    function automatic t_pixel shade_pixel(logic signed [DATA_W-1:0] dval);
        longint unsigned mag;
        longint unsigned sigma;
        longint unsigned num;
        longint unsigned den;
        longint unsigned k;
        longint unsigned core;
        longint unsigned inten;
        longint unsigned pulse;
        longint unsigned frac;
        longint unsigned j;
        t_pixel          px;
        mag   = (dval < 0) ? longint'(-longint'(dval)) : longint'(dval);
        sigma = 196608 + 10 * longint'(roughness_r);
        num   = ((mag * mag) << 15) * EXP_TABLE_DEPTH;
        den   = 16 * sigma * sigma;
        k     = (num + den / 2) / den;
        core  = (k < EXP_TABLE_DEPTH) ? gauss_core(k) : 0;
        inten = (core * longint'(gain_r) + (64'd1 << 25)) >> 26;
        // Anything at or below the bloom threshold is dropped; 1.0 and above saturates.
        if (inten <= longint'(threshold_r)) inten = 0;
        if (inten > 64'hFFFF) inten = 64'hFFFF;
        if (speed_r == 0) begin
            pulse = ONE_Q30;
        end else begin
            frac = (longint'(time_r) * longint'(speed_r)) & 64'hFFFFFF;
            j    = (frac * SINE_TABLE_DEPTH + (64'd1 << 23)) >> 24;
            if (j >= SINE_TABLE_DEPTH) j = j - SINE_TABLE_DEPTH;
            pulse = pulse_at(j);
        end
        px.glow  = DATA_W'(inten);
        px.red   = tint(red_r, inten, pulse);
        px.green = tint(green_r, inten, pulse);
        px.blue  = tint(blue_r, inten, pulse);
        return px;
    endfunction

    // Register writes, input transfers and result checks, all sampled on the rising edge.
    // A write takes effect for an input transfer on the same edge, as in the block.
    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            roughness_r = 0;
            gain_r      = 4096;
            threshold_r = 0;
            red_r       = 4096;
            green_r     = 4096;
            blue_r      = 4096;
            speed_r     = 0;
            time_r      = 0;
            pixels_due.delete();
            o_errors    = 0;
            o_pending   = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ROUGHNESS:   roughness_r = i_cfg_data[15:0];
                    CFG_EMISSIVE:    gain_r      = i_cfg_data[15:0];
                    CFG_THRESHOLD:   threshold_r = i_cfg_data[15:0];
                    CFG_COLOR_RED:   red_r       = i_cfg_data[15:0];
                    CFG_COLOR_GREEN: green_r     = i_cfg_data[15:0];
                    CFG_COLOR_BLUE:  blue_r      = i_cfg_data[15:0];
                    CFG_PULSE_SPEED: speed_r     = i_cfg_data[15:0];
                    CFG_ANIM_TIME:   time_r      = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) pixels_due.push_back(shade_pixel(i_edge_dist));
            if (i_out_valid && i_out_ready) begin
                if (pixels_due.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("Unexpected result transfer at %0t", $realtime);
                end else begin
                    want = pixels_due.pop_front();
                    if (want !== {i_glow, i_out_red, i_out_green, i_out_blue}) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("Mismatch at %0t: expected %h %h %h %h, got %h %h %h %h",
                                     $realtime, want.glow, want.red, want.green, want.blue,
                                     i_glow, i_out_red, i_out_green, i_out_blue);
                    end
                end
            end
            o_pending = pixels_due.size();
        end
    end

endmodule

// ----- test/neon_glow_shader_tb.sv -----
// Testbench top for the neon glow shader: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 1ps

module neon_glow_shader_tb;
    import ngs_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 4000;

    logic                     i_clk = 0;
    logic                     i_rst_n = 0;
    logic                     i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                     i_in_valid = 0;
    logic                     o_in_ready;
    logic signed [DATA_W-1:0] i_edge_dist = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 0;
    logic [DATA_W-1:0]        o_glow;
    logic [DATA_W-1:0]        o_out_red;
    logic [DATA_W-1:0]        o_out_green;
    logic [DATA_W-1:0]        o_out_blue;
    int                       mismatches;
    int                       pixels_pending;
    logic                     gaps_on = 1;
    int                       quiet_cycles = 0;
    int                       sink_hold = 0;

    always #1 i_clk = ~i_clk;

    neon_glow_shader dut (.*);

    ngs_checker checker_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_edge_dist(i_edge_dist), .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_glow(o_glow), .i_out_red(o_out_red), .i_out_green(o_out_green),
        .i_out_blue(o_out_blue), .o_errors(mismatches), .o_pending(pixels_pending)
    );

    // Result side: random bursts of back-pressure.
    always @(negedge i_clk) begin
        if (!gaps_on) begin
            i_out_ready <= 1;
        end else if (sink_hold > 0) begin
            sink_hold   <= sink_hold - 1;
            i_out_ready <= 0;
        end else if ($urandom_range(0, 4) == 0) begin
            sink_hold   <= $urandom_range(0, 2);
            i_out_ready <= 0;
        end else begin
            i_out_ready <= 1;
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Hold one edge distance until its transfer, with an occasional gap in front of it.
    task automatic send_dist(logic signed [DATA_W-1:0] dval);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            i_in_valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  = 1;
        i_edge_dist = dval;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Let the pipeline empty before anything about the settings changes.
    task automatic drain();
        i_in_valid = 0;
        while (pixels_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   = 1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 0;
    endtask

    task automatic set_material(logic [15:0] rough, logic [15:0] gain, logic [15:0] thresh,
                                logic [15:0] red, logic [15:0] green, logic [15:0] blue,
                                logic [15:0] speed, logic [31:0] anim);
        drain();
        write_reg(CFG_ROUGHNESS, rough);
        write_reg(CFG_EMISSIVE, gain);
        write_reg(CFG_THRESHOLD, thresh);
        write_reg(CFG_COLOR_RED, red);
        write_reg(CFG_COLOR_GREEN, green);
        write_reg(CFG_COLOR_BLUE, blue);
        write_reg(CFG_PULSE_SPEED, speed);
        write_reg(CFG_ANIM_TIME, anim);
    endtask

    // Mostly distances inside the visible falloff, now and then any 16-bit value.
    function automatic logic signed [DATA_W-1:0] pick_dist();
        logic [15:0] mag;
        if ($urandom_range(0, 4) == 0) return DATA_W'($urandom);
        mag = $urandom_range(0, $urandom_range(0, 3) == 0 ? 16000 : 2600);
        return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [15:0] pick_extreme16();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic signed [DATA_W-1:0] corners [14];
        corners = '{16'sh0000, 16'sh0001, -16'sh0001, 16'sh7FFF, -16'sh8000, 16'sh0100,
                    16'sh0300, -16'sh0C00, 16'sh2000, 16'sh1800, 16'sh5555, -16'sh2AAB,
                    16'sh0E00, 16'sh0F80};
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Defaults after reset: sharpest falloff, no pulse.
        foreach (corners[i]) send_dist(corners[i]);

        // Widest falloff, full gain (saturating glow), top colours, fastest pulse.
        set_material(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 32'hFFFF_FFFF);
        foreach (corners[i]) send_dist(corners[i]);

        // Zero gain, then a threshold that only a saturating glow passes.
        set_material(16'h8000, 16'h0000, 16'h0000, 16'h1000, 16'h2000, 16'h3000,
                     16'h0100, 32'h0000_4000);
        for (int i = 0; i < 6; i++) send_dist(corners[i]);
        set_material(16'h0000, 16'h1000, 16'hFFFF, 16'h1000, 16'h1000, 16'h1000,
                     16'h0001, 32'h0001_8000);
        for (int i = 0; i < 6; i++) send_dist(corners[i]);

        // Random materials; the last phase runs without any idling.
        for (int phase = 0; phase < 9; phase++) begin
            set_material(pick_extreme16(),
                         $urandom_range(0, 1) ? 16'($urandom_range(0, 8192)) : pick_extreme16(),
                         $urandom_range(0, 2) ? 16'($urandom_range(0, 40000)) : pick_extreme16(),
                         pick_extreme16(), pick_extreme16(), pick_extreme16(),
                         $urandom_range(0, 3) == 0 ? 16'h0000 : 16'($urandom),
                         $urandom);
            if (phase == 8) gaps_on = 0;
            repeat (210) send_dist(pick_dist());
        end

        i_in_valid = 0;
        while (pixels_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule
